/* hdl/positional_array_list_macros.svh */
// Assertion helpers included by positional_array_list.sv to check behavior.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pal assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pal assertion failed (next cycle)");

`endif

/* hdl/pal_pkg.sv */
package pal_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  // wide enough for the 5-bit position, the length and length + 1
  localparam int CMP_W    = ((LEN_W > 5) ? LEN_W : 5) + 1;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_FIND,
    CMD_UPDATE
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_POS,
    ST_FULL,
    ST_NOT_FOUND
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_UPDATE
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t         op;
    logic [CMP_W-1:0] k;    // 0-based target slot for insert and delete
    logic [CMP_W-1:0] len;  // current list length
  } cell_ctl_t;

endpackage

/* hdl/pal_if.sv */
interface pal_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  position;
  logic signed [31:0] value;
  logic signed [31:0] new_value;

  modport source (output valid, command, position, value, new_value, input ready);
  modport sink (input valid, command, position, value, new_value, output ready);
endinterface

interface pal_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] found_position;
  logic [4:0] list_count;

  modport source (output valid, status, found_position, list_count, input ready);
  modport sink (input valid, status, found_position, list_count, output ready);
endinterface

/* hdl/pal_cell.sv */
module pal_cell (
  input  logic                                clk,
  input  logic [pal_pkg::IDX_W-1:0]           idx,
  input  pal_pkg::cell_ctl_t                  ctl,
  input  logic [pal_pkg::DATA_W-1:0]          value,
  input  logic [pal_pkg::DATA_W-1:0]          new_value,
  input  logic [pal_pkg::DATA_W-1:0]          left_data,
  input  logic [pal_pkg::DATA_W-1:0]          right_data,
  input  logic                                hit_in,
  input  logic [pal_pkg::CMP_W-1:0]           pos_in,
  output logic [pal_pkg::DATA_W-1:0]          data,
  output logic                                hit_out,
  output logic [pal_pkg::CMP_W-1:0]           pos_out,
  output logic                                first
);

  logic [pal_pkg::CMP_W-1:0] idx_w;
  logic                      active;
  logic                      hit_raw;
  logic [pal_pkg::DATA_W-1:0] data_next;

  assign idx_w   = pal_pkg::CMP_W'(idx);
  assign active  = idx_w < ctl.len;
  assign hit_raw = active && (data == value);
  assign first   = hit_raw && !hit_in;
  assign hit_out = hit_in || hit_raw;
  // only the first hit contributes its 1-based position
  assign pos_out = pos_in | (first ? (idx_w + 1'b1) : '0);

  always_comb begin
    data_next = data;
    unique case (ctl.op)
      pal_pkg::OP_INSERT: begin
        if (idx_w > ctl.k) begin
          data_next = left_data;
        end else if (idx_w == ctl.k) begin
          data_next = value;
        end
      end
      pal_pkg::OP_DELETE: begin
        if (idx_w >= ctl.k) begin
          data_next = right_data;
        end
      end
      pal_pkg::OP_UPDATE: begin
        if (first) begin
          data_next = new_value;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* hdl/positional_array_list.sv */
// Channel | Dir | Payload                                  | Handshake
// req     | in  | command, position, value, new_value       | valid / ready
// rsp     | out | status, found_position, list_count       | valid / ready
//
// One request completes per cycle while rsp.ready stays high: the whole cell chain
// shifts or compares in the cycle the request is accepted, and the response is
// registered for the next cycle. Throughput is set by the single response register:
// req.ready is high while the response register is empty or being drained.
// Reset (rst, synchronous) empties the list, drops any pending response and holds
// req.ready low. A stalled response holds; list contents need no reset.
`include "positional_array_list_macros.svh"

module positional_array_list (
  input logic      clk,
  input logic      rst,
  pal_req_if.sink   req,
  pal_rsp_if.source rsp
);

  localparam int N = pal_pkg::CAPACITY;

  logic [pal_pkg::LEN_W-1:0]  len;
  logic [pal_pkg::LEN_W-1:0]  len_next;
  logic                       acc;
  logic [pal_pkg::CMP_W-1:0]  pos_w;
  logic [pal_pkg::CMP_W-1:0]  len_w;
  pal_pkg::cell_ctl_t         ctl;
  pal_pkg::status_t           status_next;
  logic [4:0]                 found_next;

  logic [pal_pkg::DATA_W-1:0] cell_data [N];
  logic [N:0]                 hit_chain;
  logic [pal_pkg::CMP_W-1:0]  pos_chain [N+1];
  logic [N-1:0]               first_vec;

  logic                       rsp_valid;
  pal_pkg::status_t           rsp_status;
  logic [4:0]                 rsp_found;
  logic [4:0]                 rsp_count;

  logic                       acc_ins;
  logic                       acc_search;
  logic                       rsp_ok;
  logic                       rsp_miss;

  assign req.ready = !rst && (!rsp_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign pos_w     = pal_pkg::CMP_W'(req.position);
  assign len_w     = pal_pkg::CMP_W'(len);

  always_comb begin
    ctl.op      = pal_pkg::OP_HOLD;
    ctl.k       = pos_w - 1'b1;
    ctl.len     = len_w;
    status_next = pal_pkg::ST_OK;
    found_next  = '0;
    len_next    = len;
    unique case (req.command)
      pal_pkg::CMD_INSERT: begin
        if ((pos_w == '0) || (pos_w > len_w + 1'b1)) begin
          status_next = pal_pkg::ST_BAD_POS;
        end else if (len_w == pal_pkg::CMP_W'(N)) begin
          status_next = pal_pkg::ST_FULL;
        end else begin
          ctl.op   = pal_pkg::OP_INSERT;
          len_next = len + 1'b1;
        end
      end
      pal_pkg::CMD_DELETE: begin
        if ((pos_w == '0) || (pos_w > len_w)) begin
          status_next = pal_pkg::ST_BAD_POS;
        end else begin
          ctl.op   = pal_pkg::OP_DELETE;
          len_next = len - 1'b1;
        end
      end
      default: begin
        found_next = pos_chain[N][4:0];
        if (!hit_chain[N]) begin
          status_next = pal_pkg::ST_NOT_FOUND;
        end else if (req.command == pal_pkg::CMD_UPDATE) begin
          ctl.op = pal_pkg::OP_UPDATE;
        end
      end
    endcase
    // nothing moves unless the request is taken
    if (!acc) begin
      ctl.op = pal_pkg::OP_HOLD;
    end
  end

  assign hit_chain[0] = 1'b0;
  assign pos_chain[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [pal_pkg::DATA_W-1:0] left_d;
    logic [pal_pkg::DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = req.value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    pal_cell u_cell (
      .clk        (clk),
      .idx        (pal_pkg::IDX_W'(i)),
      .ctl        (ctl),
      .value      (req.value),
      .new_value  (req.new_value),
      .left_data  (left_d),
      .right_data (right_d),
      .hit_in     (hit_chain[i]),
      .pos_in     (pos_chain[i]),
      .data       (cell_data[i]),
      .hit_out    (hit_chain[i+1]),
      .pos_out    (pos_chain[i+1]),
      .first      (first_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        len       <= len_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_status <= status_next;
      rsp_found  <= found_next;
      rsp_count  <= 5'(len_next);
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.found_position = rsp_found;
  assign rsp.list_count     = rsp_count;

  assign acc_ins    = acc && (req.command == pal_pkg::CMD_INSERT);
  assign acc_search = acc && ((req.command == pal_pkg::CMD_FIND)
                              || (req.command == pal_pkg::CMD_UPDATE));
  assign rsp_ok     = (rsp_status == pal_pkg::ST_OK);
  assign rsp_miss   = (rsp_status == pal_pkg::ST_NOT_FOUND);

  `PAL_ASSERT_SAME(a_first_unique, clk, rst, 1'b1, $onehot0(first_vec))
  `PAL_ASSERT_SAME(a_len_bound, clk, rst, 1'b1, len_w <= pal_pkg::CMP_W'(N))
  `PAL_ASSERT_NEXT(a_ins_len, clk, rst, acc_ins, rsp_ok == (len != $past(len)))
  `PAL_ASSERT_NEXT(a_search_pos, clk, rst, acc_search, rsp_miss == (rsp_found == '0))

endmodule

/* bench/tb_positional_array_list.sv */
`timescale 1ns / 100ps

module tb_positional_array_list;
  import pal_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [4:0] found_position;
    logic [4:0] list_count;
  } list_result_t;

  typedef struct packed {
    cmd_t         command;
    logic [4:0]   position;
    logic [31:0]  value;
    logic [31:0]  new_value;
    logic         fixed;
    list_result_t result;
  } list_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BLEND,
    MIX_SEARCH
  } mix_t;

  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASE_LEN    = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIRECTED_COUNT = 24;

  // rows with fixed set carry their own result; the rest take theirs from the list predictor
  localparam list_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{CMD_FIND,   5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd0}},
    '{CMD_UPDATE, 5'd0,  32'h0000_0000, 32'h0000_0001, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd0}},
    '{CMD_DELETE, 5'd1,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_BAD_POS,   5'd0, 5'd0}},
    '{CMD_DELETE, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_BAD_POS,   5'd0, 5'd0}},
    '{CMD_INSERT, 5'd0,  32'h0000_0005, 32'h0000_0000, 1'b1, '{ST_BAD_POS,   5'd0, 5'd0}},
    '{CMD_INSERT, 5'd2,  32'h0000_0005, 32'h0000_0000, 1'b1, '{ST_BAD_POS,   5'd0, 5'd0}},
    '{CMD_INSERT, 5'd31, 32'h0000_0005, 32'h0000_0000, 1'b1, '{ST_BAD_POS,   5'd0, 5'd0}},
    '{CMD_INSERT, 5'd1,  32'h8000_0000, 32'h0000_0000, 1'b1, '{ST_OK,        5'd0, 5'd1}},
    '{CMD_INSERT, 5'd2,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK,        5'd0, 5'd2}},
    '{CMD_INSERT, 5'd1,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_INSERT, 5'd2,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_FIND,   5'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_FIND,   5'd31, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_INSERT, 5'd5,  32'h0000_0000, 32'h0000_0000, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_FIND,   5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_UPDATE, 5'd0,  32'h0000_0000, 32'hAAAA_5555, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_FIND,   5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_UPDATE, 5'd0,  32'h0000_1234, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd5}},
    '{CMD_DELETE, 5'd6,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_BAD_POS,   5'd0, 5'd5}},
    '{CMD_DELETE, 5'd5,  32'h0000_0000, 32'h0000_0000, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_DELETE, 5'd1,  32'h0000_0000, 32'h0000_0000, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_DELETE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_BAD_POS,   5'd0, 5'd3}},
    '{CMD_INSERT, 5'd4,  32'h5555_AAAA, 32'hFFFF_FFFF, 1'b0, '{ST_OK,        5'd0, 5'd0}},
    '{CMD_INSERT, 5'd6,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_BAD_POS,   5'd0, 5'd4}}
  };

  logic clk = 1'b0;
  logic rst;

  pal_req_if req_bus ();
  pal_rsp_if rsp_bus ();

  positional_array_list u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [31:0]  shadow_words [CAPACITY];
  int unsigned  shadow_len = 0;
  list_result_t expected_results [$];
  list_row_t    pending_row;
  bit           steady_flow = 1'b0;
  int           mismatch_count = 0;

  // Apply one command to the shadow list and return the response it should produce.
  function automatic list_result_t apply_list_command(cmd_t cmd, logic [4:0] pos,
                                                      logic [31:0] val, logic [31:0] nval);
    list_result_t res;
    int p;
    int hit;
    p = pos;
    hit = 0;
    res.status = ST_OK;
    res.found_position = '0;
    case (cmd)
      CMD_INSERT: begin
        if (p == 0 || p > shadow_len + 1) begin
          res.status = ST_BAD_POS;
        end else if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > p - 1; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[p - 1] = val;
          shadow_len++;
        end
      end
      CMD_DELETE: begin
        if (p == 0 || p > shadow_len) begin
          res.status = ST_BAD_POS;
        end else begin
          for (int i = p; i < shadow_len; i++) shadow_words[i - 1] = shadow_words[i];
          shadow_len--;
        end
      end
      default: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (hit == 0 && shadow_words[i] == val) hit = i + 1;
        end
        if (hit == 0) begin
          res.status = ST_NOT_FOUND;
        end else if (cmd == CMD_UPDATE) begin
          shadow_words[hit - 1] = nval;
        end
        res.found_position = hit[4:0];
      end
    endcase
    res.list_count = shadow_len[4:0];
    return res;
  endfunction

  // Predict on acceptance, then match any response against the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        want = apply_list_command(cmd_t'(req_bus.command), req_bus.position,
                                  req_bus.value, req_bus.new_value);
        if (pending_row.fixed) want = pending_row.result;
        expected_results.push_back(want);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("response with none outstanding: status %0d found_position %0d count %0d",
                 rsp_bus.status, rsp_bus.found_position, rsp_bus.list_count);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            mismatch_count++;
          end
          if (rsp_bus.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, rsp_bus.found_position);
            mismatch_count++;
          end
          if (rsp_bus.list_count !== want.list_count) begin
            $error("list_count: expected %0d, got %0d", want.list_count, rsp_bus.list_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Response side: stall a random number of cycles before taking each response, except in steady-flow phases.
  initial begin
    int stall;
    rsp_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // Hold a request until accepted; keep valid high when the next one follows at once.
  task automatic send_request(input list_row_t row);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.command   <= row.command;
    req_bus.position  <= row.position;
    req_bus.value     <= row.value;
    req_bus.new_value <= row.new_value;
    pending_row       <= row;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  initial begin
    list_row_t row;
    mix_t      mix;
    int        roll;
    int        ins_pct;
    int        del_pct;
    rst               <= 1'b1;
    req_bus.valid     <= 1'b0;
    req_bus.command   <= '0;
    req_bus.position  <= '0;
    req_bus.value     <= '0;
    req_bus.new_value <= '0;
    pending_row       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIRECTED_COUNT; n++) send_request(DIRECTED_ROWS[n]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        mix = mix_t'((n / PHASE_LEN) % 4);
        steady_flow = ((n / PHASE_LEN) % 3 == 2);
      end
      case (mix)
        MIX_FILL:  begin ins_pct = 70; del_pct = 10; end
        MIX_DRAIN: begin ins_pct = 10; del_pct = 70; end
        MIX_BLEND: begin ins_pct = 30; del_pct = 25; end
        default:   begin ins_pct = 20; del_pct = 15; end
      endcase
      row = '0;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) row.command = CMD_INSERT;
      else if (roll < ins_pct + del_pct) row.command = CMD_DELETE;
      else if ($urandom_range(0, 1) == 0) row.command = CMD_FIND;
      else row.command = CMD_UPDATE;

      // mostly in-range positions, now and then anything the field holds
      if ($urandom_range(0, 9) == 0) row.position = 5'($urandom_range(0, 31));
      else row.position = 5'($urandom_range(1, shadow_len + 1));

      // favor values already in the list and a small pool that repeats
      roll = $urandom_range(0, 9);
      if (roll < 4 && shadow_len > 0) row.value = shadow_words[$urandom_range(0, shadow_len - 1)];
      else if (roll < 7) row.value = 32'($urandom_range(0, 7)) - 32'd4;
      else row.value = $urandom;
      if ($urandom_range(0, 1) == 0) row.new_value = 32'($urandom_range(0, 7)) - 32'd4;
      else row.new_value = $urandom;

      send_request(row);
    end
    req_bus.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("positional_array_list: match");
    end else begin
      $display("positional_array_list: mismatch");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("positional_array_list: mismatch");
    $finish;
  end

endmodule
